FILE: hw/rtl/ora_pkg.sv
// Shared types and codes for the outbound region allocator.
// No dependencies; imported by outbound_region_allocator_top, ora_checker and tb_top.
`default_nettype none

package ora_pkg;

  // Fixed top of the outbound window.
  localparam logic [63:0] WIN_END = 64'h0000_0000_1fff_ffff;

  // Operation codes.
  localparam logic [1:0] FN_MAP   = 2'd0;
  localparam logic [1:0] FN_UNMAP = 2'd1;
  localparam logic [1:0] FN_XLATE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVAL   = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_NOSPACE = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [63:0]        host_target;
    logic signed [31:0] map_size;
    logic [2:0]         region_index;
    logic [63:0]        host_address;
  } ora_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  granted_region;
    logic [63:0] window_address;
    logic [31:0] limit_address;
  } ora_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/outbound_region_allocator_top.sv
// Outbound region allocator: region table, map / unmap / translate in one pass.
// Depends on ora_pkg for the request and result types and the codes.
`default_nettype none

// One request is taken on every clock edge at which start is high; busy is
// never raised, so a request may follow in every cycle. Each request gives
// exactly one result, shown on out_data with out_valid high for one cycle:
// the request is held in the request register, then a single pass of
// decode, first-free search and 64-bit address arithmetic fills the result
// register. The receiver cannot stall the block.
// ALIGN_BYTES must be a power of two. The region size is worked out when
// the design is built from WINDOW_START, REGION_COUNT and ALIGN_BYTES.
module outbound_region_allocator_top
  import ora_pkg::*;
#(
  parameter int unsigned REGION_COUNT = 6,
  parameter int unsigned ALIGN_BYTES  = 65536,
  parameter logic [31:0] WINDOW_START = 32'h1000_0000
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire ora_req_t in_data,
  output logic          out_valid,
  output ora_res_t      out_data
);

  localparam int unsigned IDX_W      = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int unsigned ALIGN_LOG2 = $clog2(ALIGN_BYTES);
  localparam logic [63:0] START64    = {32'd0, WINDOW_START};
  localparam logic [63:0] PER_REGION =
    (START64 > WIN_END) ? 64'd0 : (WIN_END - START64) / REGION_COUNT;
  localparam logic [63:0] SPAN       = (PER_REGION / ALIGN_BYTES) * ALIGN_BYTES;
  localparam logic [3:0]  COUNT4     = 4'(REGION_COUNT);

  logic                    in_valid_r;
  ora_req_t                in_r;
  logic                    out_valid_r;
  ora_res_t                out_r;
  ora_res_t                out_nxt;
  logic [REGION_COUNT-1:0] busy_r;
  logic [REGION_COUNT-1:0] busy_nxt;
  logic [63:0]             target_r   [REGION_COUNT];
  logic [63:0]             target_nxt [REGION_COUNT];

  logic        free_found;
  logic [2:0]  free_idx;
  logic [2:0]  sel_idx;
  logic [63:0] sel_base;
  logic [63:0] sel_target;
  logic        idx_in_range;
  logic [63:0] size64;

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Lowest free region.
  always_comb begin
    free_found = 1'b0;
    free_idx   = 3'd0;
    for (int i = REGION_COUNT - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = 3'(i);
      end
    end
  end

  assign idx_in_range = {1'b0, in_r.region_index} < COUNT4;
  assign sel_idx      = (in_r.func == FN_MAP) ? free_idx : in_r.region_index;
  assign sel_base     = START64 + 64'(sel_idx) * SPAN;
  assign sel_target   = idx_in_range ? target_r[in_r.region_index[IDX_W-1:0]] : 64'd0;
  assign size64       = {32'd0, in_r.map_size};

  always_comb begin
    busy_nxt   = busy_r;
    target_nxt = target_r;
    out_nxt    = '0;
    unique case (in_r.func)
      FN_MAP: begin
        if (in_r.map_size[31] || (in_r.map_size == 32'sd0)) begin
          out_nxt.status = ST_INVAL;
        end else if (size64 > SPAN) begin
          out_nxt.status = ST_RANGE;
        end else if (in_r.host_target[ALIGN_LOG2-1:0] != '0) begin
          out_nxt.status = ST_INVAL;
        end else if (!free_found) begin
          out_nxt.status = ST_NOSPACE;
        end else begin
          out_nxt.status         = ST_OK;
          out_nxt.granted_region = free_idx;
          out_nxt.window_address = sel_base;
          out_nxt.limit_address  = sel_base[31:0] + in_r.map_size[31:0] - 32'd1;
          busy_nxt[free_idx[IDX_W-1:0]]   = 1'b1;
          target_nxt[free_idx[IDX_W-1:0]] = in_r.host_target;
        end
      end
      FN_UNMAP: begin
        out_nxt.status = ST_OK;
        if (idx_in_range) begin
          busy_nxt[in_r.region_index[IDX_W-1:0]]   = 1'b0;
          target_nxt[in_r.region_index[IDX_W-1:0]] = 64'd0;
        end
      end
      FN_XLATE: begin
        if (idx_in_range) begin
          out_nxt.status         = ST_OK;
          out_nxt.window_address = sel_base + (in_r.host_address - sel_target);
        end else begin
          out_nxt.status = ST_INVAL;
        end
      end
      default: begin
        out_nxt.status = ST_INVAL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    in_r  <= in_data;
    out_r <= out_nxt;
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= '0;
      for (int i = 0; i < REGION_COUNT; i++) begin
        target_r[i] <= 64'd0;
      end
    end else begin
      in_valid_r  <= start;
      out_valid_r <= in_valid_r;
      // Commit table changes only for a real request.
      if (in_valid_r) begin
        busy_r   <= busy_nxt;
        target_r <= target_nxt;
      end
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_valid_r)
    else $error("request register beat lost before the result register");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |=> !out_valid_r)
    else $error("result strobe without a request");

  a_map_claims_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && in_r.func == FN_MAP && out_nxt.status == ST_OK)
      |=> $countones(busy_r) == $past($countones(busy_r)) + 1)
    else $error("successful map did not claim exactly one region");

  a_nospace_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && in_r.func == FN_MAP && out_nxt.status == ST_NOSPACE) |-> &busy_r)
    else $error("no-space status while a region is free");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK)
      |-> (out_r.granted_region == 3'd0 && out_r.window_address == 64'd0))
    else $error("error result carries a region or address");

endmodule

`default_nettype wire

FILE: test/ora_checker.sv
// Scoreboard for the outbound region allocator: watches the request and result
// channels, predicts each result from its own copy of the region table and compares.
// Depends on ora_pkg for the request and result types and the codes.

module ora_checker
  import ora_pkg::*;
#(
  parameter int unsigned REGION_COUNT = 6,
  parameter int unsigned ALIGN_BYTES  = 65536,
  parameter logic [31:0] WINDOW_START = 32'h1000_0000
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     busy,
  input  wire ora_req_t in_data,
  input  wire logic     out_valid,
  input  wire ora_res_t out_data,
  output int            mismatches,
  output int            outstanding
);

  localparam int unsigned PRINT_CAP = 40;

  logic        slot_taken  [REGION_COUNT];
  logic [63:0] slot_target [REGION_COUNT];
  ora_res_t    awaited_results [$];
  ora_res_t    head;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [63:0] region_bytes();
    logic [63:0] lo;
    logic [63:0] per;
    lo = 64'(WINDOW_START);
    if (lo > WIN_END) return 64'd0;
    per = (WIN_END - lo) / 64'(REGION_COUNT);
    return (per / 64'(ALIGN_BYTES)) * 64'(ALIGN_BYTES);
  endfunction

  function automatic logic [63:0] region_base(input int unsigned idx);
    return 64'(WINDOW_START) + 64'(idx) * region_bytes();
  endfunction

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    if (mismatches < PRINT_CAP)
      $display("ora_checker: %s mismatch at %0t: got %h expected %h", field, $time, got, want);
    mismatches++;
  endtask

  // Apply one request to the table copy and return the result it must produce.
  function automatic ora_res_t resolve_request(input ora_req_t req);
    ora_res_t    res;
    logic [63:0] size;
    logic        placed;
    int unsigned idx;
    int unsigned i;
    res    = '0;
    placed = 1'b0;
    size   = {32'd0, req.map_size};
    idx    = int'(req.region_index);
    case (req.func)
      FN_MAP: begin
        if (req.map_size[31] || size == 64'd0) begin
          res.status = ST_INVAL;
        end else if (size > region_bytes()) begin
          res.status = ST_RANGE;
        end else if ((req.host_target % 64'(ALIGN_BYTES)) != 64'd0) begin
          res.status = ST_INVAL;
        end else begin
          res.status = ST_NOSPACE;
          for (i = 0; i < REGION_COUNT; i++) begin
            if (!placed && !slot_taken[i]) begin
              placed             = 1'b1;
              slot_taken[i]      = 1'b1;
              slot_target[i]     = req.host_target;
              res.status         = ST_OK;
              res.granted_region = 3'(i);
              res.window_address = region_base(i);
              res.limit_address  = 32'(region_base(i) + size - 64'd1);
            end
          end
        end
      end
      FN_UNMAP: begin
        if (idx < REGION_COUNT) begin
          slot_taken[idx]  = 1'b0;
          slot_target[idx] = 64'd0;
        end
      end
      FN_XLATE: begin
        if (idx < REGION_COUNT)
          res.window_address = region_base(idx) + (req.host_address - slot_target[idx]);
        else
          res.status = ST_INVAL;
      end
      default: res.status = ST_INVAL;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REGION_COUNT; i++) begin
        slot_taken[i]  = 1'b0;
        slot_target[i] = 64'd0;
      end
      awaited_results.delete();
      outstanding <= 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (awaited_results.size() == 0) begin
          report("unawaited result", {62'd0, out_data.status}, 64'd0);
        end else begin
          head = awaited_results.pop_front();
          if (out_data.status !== head.status)
            report("status", {62'd0, out_data.status}, {62'd0, head.status});
          if (out_data.granted_region !== head.granted_region)
            report("granted_region", {61'd0, out_data.granted_region},
                   {61'd0, head.granted_region});
          if (out_data.window_address !== head.window_address)
            report("window_address", out_data.window_address, head.window_address);
          if (out_data.limit_address !== head.limit_address)
            report("limit_address", {32'd0, out_data.limit_address},
                   {32'd0, head.limit_address});
        end
      end
      if (start === 1'b1 && busy !== 1'b1)
        awaited_results.push_back(resolve_request(in_data));
      outstanding <= awaited_results.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// Top of the outbound region allocator testbench: clock, reset, request stimulus
// and verdict. Depends on ora_pkg, outbound_region_allocator_top and ora_checker.

module tb_top;
  import ora_pkg::*;

  localparam int unsigned REGION_COUNT = 6;
  localparam int unsigned ALIGN_BYTES  = 65536;
  localparam logic [31:0] WINDOW_START = 32'h1000_0000;

  localparam logic [1:0]  FN_UNDEF     = 2'd3;
  localparam logic [63:0] REGION_BYTES =
    ((WIN_END - 64'(WINDOW_START)) / 64'(REGION_COUNT)) / 64'(ALIGN_BYTES) * 64'(ALIGN_BYTES);
  localparam logic [63:0] ALIGN_MASK   = ~(64'(ALIGN_BYTES) - 64'd1);
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned DRAIN_LIMIT  = 1000;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic     clk   = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  ora_req_t in_data = '0;
  logic     out_valid;
  ora_res_t out_data;
  int       mismatches;
  int       outstanding;
  int       cycles   = 0;
  int       idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  outbound_region_allocator_top #(
    .REGION_COUNT (REGION_COUNT),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .WINDOW_START (WINDOW_START)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  ora_checker #(
    .REGION_COUNT (REGION_COUNT),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .WINDOW_START (WINDOW_START)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic ora_req_t make_req(input logic [1:0] func, input logic [63:0] target,
                                        input logic [31:0] size, input logic [2:0] idx,
                                        input logic [63:0] addr);
    ora_req_t req;
    req.func         = func;
    req.host_target  = target;
    req.map_size     = size;
    req.region_index = idx;
    req.host_address = addr;
    return req;
  endfunction

  // Mostly well-formed maps, unmaps and translations against a churning table, with some noise.
  function automatic ora_req_t random_req();
    ora_req_t    req;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 36)      req.func = FN_MAP;
    else if (pick < 62) req.func = FN_UNMAP;
    else if (pick < 96) req.func = FN_XLATE;
    else                req.func = FN_UNDEF;
    pick = $urandom_range(9);
    req.host_target = {$urandom, $urandom};
    if (pick < 8)
      req.host_target = req.host_target & ALIGN_MASK;
    else if (pick == 9)
      req.host_target = 64'($urandom_range(255)) * 64'(ALIGN_BYTES);
    pick = $urandom_range(19);
    case (pick)
      14:      req.map_size = 32'(REGION_BYTES);
      15:      req.map_size = 32'd1;
      16:      req.map_size = $urandom_range(32'h7fff_ffff, 32'(REGION_BYTES) + 32'd1);
      17:      req.map_size = 32'd0;
      18:      req.map_size = $urandom;
      19:      req.map_size = $urandom | 32'h8000_0000;
      default: req.map_size = $urandom_range(32'(REGION_BYTES), 1);
    endcase
    req.region_index = 3'($urandom_range(7));
    req.host_address = {$urandom, $urandom};
    return req;
  endfunction

  // Hold the beat on the port until the block takes it; start stays high afterwards.
  task automatic send(input ora_req_t req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy === 1'b1);
  endtask

  task automatic wait_drained();
    int unsigned n;
    n     = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (outstanding != 0 && n < DRAIN_LIMIT);
  endtask

  initial begin
    int unsigned phase_pct [4];
    int unsigned k;
    phase_pct = '{0, 72, 0, 29};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Error precedence first: size before range before alignment.
    send(make_req(FN_MAP, 64'd1, 32'd0, 3'd0, 64'd0));
    send(make_req(FN_MAP, 64'd0, 32'hffff_ffff, 3'd0, 64'd0));
    send(make_req(FN_MAP, 64'd0, 32'h8000_0000, 3'd0, 64'd0));
    send(make_req(FN_MAP, 64'd3, 32'(REGION_BYTES) + 32'd1, 3'd0, 64'd0));
    send(make_req(FN_MAP, 64'd0, 32'h7fff_ffff, 3'd0, 64'd0));
    send(make_req(FN_MAP, 64'h8000, 32'd1, 3'd0, 64'd0));
    // Fill the table, then overflow it.
    send(make_req(FN_MAP, 64'hffff_ffff_ffff_0000, 32'(REGION_BYTES), 3'd0, 64'd0));
    send(make_req(FN_MAP, 64'd0, 32'd1, 3'd0, 64'd0));
    for (k = 2; k < REGION_COUNT; k++)
      send(make_req(FN_MAP, {$urandom, $urandom} & ALIGN_MASK,
                    $urandom_range(32'(REGION_BYTES), 1), 3'd0, 64'd0));
    send(make_req(FN_MAP, 64'h0001_0000, 32'd4096, 3'd0, 64'd0));
    // Translations with wrap either way and out-of-range indexes.
    send(make_req(FN_XLATE, 64'd0, 32'd0, 3'd0, 64'hffff_ffff_ffff_ffff));
    send(make_req(FN_XLATE, 64'd0, 32'd0, 3'd0, 64'd0));
    send(make_req(FN_XLATE, 64'd0, 32'd0, 3'd6, 64'd0));
    send(make_req(FN_XLATE, 64'd0, 32'd0, 3'd7, 64'hffff_ffff_ffff_ffff));
    // Unmap out of range is dropped; a freed slot is reused by the next map.
    send(make_req(FN_UNMAP, 64'd0, 32'd0, 3'd7, 64'd0));
    send(make_req(FN_UNMAP, 64'd0, 32'd0, 3'd6, 64'd0));
    send(make_req(FN_UNMAP, 64'd0, 32'd0, 3'd2, 64'd0));
    send(make_req(FN_XLATE, 64'd0, 32'd0, 3'd2, 64'h1234_5678_9abc_def0));
    send(make_req(FN_MAP, 64'h0000_0001_0000_0000, 32'h0000_ffff, 3'd0, 64'd0));
    send(make_req(FN_UNDEF, {$urandom, $urandom}, $urandom, 3'd5, {$urandom, $urandom}));
    send(make_req(FN_UNMAP, 64'd0, 32'd0, 3'd0, 64'd0));
    send(make_req(FN_XLATE, 64'd0, 32'd0, 3'd5, {$urandom, $urandom}));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      for (k = 0; k < RANDOM_ITEMS / 4; k++)
        send(random_req());
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ora_pkg.sv
hw/rtl/outbound_region_allocator_top.sv
test/ora_checker.sv
test/tb_top.sv
